// ----- design/cdd_pkg.sv -----
// Shared types and constants for the cloud-in-cell density deposit block.
`timescale 1ns / 1ps

package cdd_pkg;

   localparam int FRAC_W    = 16;
   localparam int WT_W      = 17;
   localparam int CONTRIB_W = 33;
   localparam int DEN_W     = 48;
   localparam int POS_W     = 32;
   localparam int CELL_W    = 5;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_INV_CELL_SIZE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALED_MASS   = 8'd1;

   localparam logic [1:0] OP_DEPOSIT    = 2'd0;
   localparam logic [1:0] OP_READ       = 2'd1;
   localparam logic [1:0] OP_READ_CLEAR = 2'd2;
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   localparam logic [WT_W-1:0] ONE_Q16 = 17'h10000;

   typedef enum logic [1:0] {
      MK_ADD   = 2'd0,
      MK_READ  = 2'd1,
      MK_RDCLR = 2'd2,
      MK_CLEAR = 2'd3
   } mem_kind_type;

   typedef struct packed {
      logic         valid;
      mem_kind_type kind;
   } mem_ctl_type;

endpackage

// ----- design/cdd_weight_pipe.sv -----
// Three-stage corner weight and mass contribution pipeline.
`timescale 1ns / 1ps

module cdd_weight_pipe #(
   parameter int AW = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [cdd_pkg::WT_W-1:0]        in_a,
   input  logic [cdd_pkg::WT_W-1:0]        in_b,
   input  logic [cdd_pkg::WT_W-1:0]        in_c,
   input  logic [AW-1:0]                   in_addr,
   input  logic [31:0]                     scaled_mass,
   output logic                            out_valid,
   output logic [cdd_pkg::CONTRIB_W-1:0]   out_contrib,
   output logic [AW-1:0]                   out_addr,
   output logic                            busy
);

   logic                         v1_ff, v2_ff, v3_ff;
   logic [2*cdd_pkg::WT_W-1:0]   ab_ff;
   logic [cdd_pkg::WT_W-1:0]     c1_ff;
   logic [cdd_pkg::WT_W-1:0]     w2_ff;
   logic [cdd_pkg::CONTRIB_W-1:0] contrib3_ff;
   logic [AW-1:0]                addr1_ff, addr2_ff, addr3_ff;
   logic [2*cdd_pkg::WT_W-1:0]   abc_in;
   logic [31+cdd_pkg::WT_W:0]    mw_in;

   assign abc_in = ab_ff[32:16] * c1_ff;
   assign mw_in  = 49'(scaled_mass) * 49'(w2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      ab_ff       <= in_a * in_b;
      c1_ff       <= in_c;
      addr1_ff    <= in_addr;
      w2_ff       <= abc_in[32:16];
      addr2_ff    <= addr1_ff;
      contrib3_ff <= mw_in[48:16];
      addr3_ff    <= addr2_ff;
   end

   assign out_valid   = v3_ff;
   assign out_contrib = contrib3_ff;
   assign out_addr    = addr3_ff;
   assign busy        = v1_ff | v2_ff | v3_ff;

endmodule

// ----- design/cdd_grid_mem.sv -----
// Density grid memory with read-modify-write accumulate, saturation and clear.
`timescale 1ns / 1ps

module cdd_grid_mem #(
   parameter int CELLS = 32768,
   parameter int AW    = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cdd_pkg::mem_ctl_type          req,
   input  logic [AW-1:0]                 req_addr,
   input  logic [cdd_pkg::CONTRIB_W-1:0] req_addend,
   output logic                          rd_valid,
   output logic [cdd_pkg::DEN_W-1:0]     rd_density,
   output logic                          rd_saturated,
   output logic                          pending
);

   logic [cdd_pkg::DEN_W:0]       mem [CELLS];
   logic [cdd_pkg::DEN_W:0]       rd_q_ff;
   cdd_pkg::mem_ctl_type          p_ff;
   logic [AW-1:0]                 p_addr_ff;
   logic [cdd_pkg::CONTRIB_W-1:0] p_addend_ff;
   logic [cdd_pkg::DEN_W:0]       sum;
   logic [cdd_pkg::DEN_W:0]       acc_word;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [cdd_pkg::DEN_W:0]       wr_data;
   logic                          rd_en;

   assign sum = {1'b0, rd_q_ff[cdd_pkg::DEN_W-1:0]} + 49'(p_addend_ff);
   assign acc_word = sum[cdd_pkg::DEN_W] ? {1'b1, {cdd_pkg::DEN_W{1'b1}}}
                                         : {rd_q_ff[cdd_pkg::DEN_W], sum[cdd_pkg::DEN_W-1:0]};
   assign rd_en = req.valid && (req.kind != cdd_pkg::MK_CLEAR);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = req_addr;
      wr_data = '0;
      if (p_ff.valid && p_ff.kind == cdd_pkg::MK_ADD) begin
         wr_en   = 1'b1;
         wr_addr = p_addr_ff;
         wr_data = acc_word;
      end else if (p_ff.valid && p_ff.kind == cdd_pkg::MK_RDCLR) begin
         wr_en   = 1'b1;
         wr_addr = p_addr_ff;
      end else if (req.valid && req.kind == cdd_pkg::MK_CLEAR) begin
         wr_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_q_ff <= mem[req_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= '0;
      end else begin
         p_ff.valid <= rd_en;
         p_ff.kind  <= req.kind;
      end
      p_addr_ff   <= req_addr;
      p_addend_ff <= req_addend;
   end

   assign rd_valid = p_ff.valid &&
                     (p_ff.kind == cdd_pkg::MK_READ || p_ff.kind == cdd_pkg::MK_RDCLR);
   assign rd_density   = rd_q_ff[cdd_pkg::DEN_W-1:0];
   assign rd_saturated = rd_q_ff[cdd_pkg::DEN_W];
   assign pending      = p_ff.valid;

endmodule

// ----- design/cic_density_deposit.sv -----
// Top level of the three-dimensional cloud-in-cell density deposit block.
`timescale 1ns / 1ps

// Cloud-in-cell mass deposit onto a periodic GRID_DIM^3 grid held in one
// on-chip memory (48-bit density plus a saturation mark per cell). After
// reset the block sweeps the memory to zero, one cell per cycle, through all
// GRID_DIM^3 cells (32768 at the default); busy stays high meanwhile and
// configuration writes are still taken. A word is accepted when start is high
// and busy is low. A deposit splits the three axes through one shared
// 32x32 multiplier, then issues the eight corners one per cycle into a
// three-stage weight pipeline feeding a read-modify-write on the single
// memory port pair, and drains: busy stays high until every corner has been
// written back, so a new particle is taken only after that. An out-of-grid
// deposit ends after the axis split. A read or read-and-clear keeps busy
// high until its one word appears on the rsp_ ports, for exactly one cycle,
// marked by rsp_valid (a read of a cell outside the grid answers zero without
// a memory access); the next word can be taken in the same cycle as the word
// appears. The receiver cannot stall the result, so sample it when it
// appears. Operation 3 is taken and dropped. Write csr_ registers only while
// the block is idle.
module cic_density_deposit #(
   parameter int GRID_DIM = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic [cdd_pkg::POS_W-1:0]         req_pos_x,
   input  logic [cdd_pkg::POS_W-1:0]         req_pos_y,
   input  logic [cdd_pkg::POS_W-1:0]         req_pos_z,
   input  logic [cdd_pkg::CELL_W-1:0]        req_cell_x,
   input  logic [cdd_pkg::CELL_W-1:0]        req_cell_y,
   input  logic [cdd_pkg::CELL_W-1:0]        req_cell_z,
   output logic                              rsp_valid,
   output logic [cdd_pkg::DEN_W-1:0]         rsp_cell_density,
   output logic                              rsp_saturated,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cdd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_data
);

   localparam int CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
   localparam int AW    = $clog2(CELLS);
   localparam int IW    = $clog2(GRID_DIM);

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_SPLIT  = 7'b0000100,
      ST_CORNER = 7'b0001000,
      ST_DRAIN  = 7'b0010000,
      ST_READ   = 7'b0100000,
      ST_WAITRD = 7'b1000000
   } state_type;

   function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] x,
                                               input logic [IW-1:0] y,
                                               input logic [IW-1:0] z);
      return ((AW'(x) * AW'(GRID_DIM)) + AW'(y)) * AW'(GRID_DIM) + AW'(z);
   endfunction

   state_type                     state_ff, state_in;
   logic [31:0]                   inv_ff, mass_ff;
   logic [AW-1:0]                 clr_addr_ff, clr_addr_in;
   logic [1:0]                    op_ff;
   logic [cdd_pkg::POS_W-1:0]     pos_ff [3];
   logic [cdd_pkg::CELL_W-1:0]    cell_ff [3];
   logic [1:0]                    sp_cnt_ff, sp_cnt_in;
   logic [63:0]                   g_ff, g_in;
   logic [IW-1:0]                 lo_ff [3];
   logic [cdd_pkg::FRAC_W-1:0]    frac_ff [3];
   logic                          oob_ff, oob_in;
   logic [2:0]                    cn_ff, cn_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cdd_pkg::DEN_W-1:0]     rsp_den_ff, rsp_den_in;
   logic                          rsp_sat_ff, rsp_sat_in;

   logic [cdd_pkg::POS_W-1:0]     pos_sel;
   logic [1:0]                    ax_prev;
   logic                          axis_oob;
   logic [IW-1:0]                 hi [3];
   logic [IW-1:0]                 csel [3];
   logic [cdd_pkg::WT_W-1:0]      fac [3];
   logic                          accept;
   logic                          read_oob;

   cdd_pkg::mem_ctl_type          mreq;
   logic [AW-1:0]                 maddr;
   logic [cdd_pkg::CONTRIB_W-1:0] maddend;
   logic                          mrd_valid, mrd_sat, mpending;
   logic [cdd_pkg::DEN_W-1:0]     mrd_den;

   logic                          wp_valid, wp_out_valid, wp_busy;
   logic [cdd_pkg::CONTRIB_W-1:0] wp_contrib;
   logic [AW-1:0]                 wp_addr, corner_addr;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Configuration registers; writes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff  <= 32'h0001_0000;
         mass_ff <= 32'h0001_0000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cdd_pkg::CSR_INV_CELL_SIZE: begin
               inv_ff <= csr_data;
            end
            cdd_pkg::CSR_SCALED_MASS: begin
               mass_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Axis split: one shared multiplier, result registered, then index and
   // fraction of the previous axis are peeled off it in the following split step.
   always_comb begin
      case (sp_cnt_ff)
         2'd0:    pos_sel = pos_ff[0];
         2'd1:    pos_sel = pos_ff[1];
         2'd2:    pos_sel = pos_ff[2];
         default: pos_sel = '0;
      endcase
   end
   assign g_in     = 64'(pos_sel) * 64'(inv_ff);
   assign ax_prev  = sp_cnt_ff - 2'd1;
   assign axis_oob = (g_ff[63:32] >= 32'(GRID_DIM));

   // Corner selection: bit 2 picks x, bit 1 y, bit 0 z (upper neighbor when set).
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hi[k]   = (lo_ff[k] == IW'(GRID_DIM - 1)) ? '0 : lo_ff[k] + IW'(1);
         csel[k] = cn_ff[2-k] ? hi[k] : lo_ff[k];
         fac[k]  = cn_ff[2-k] ? {1'b0, frac_ff[k]} : cdd_pkg::ONE_Q16 - {1'b0, frac_ff[k]};
      end
   end
   assign corner_addr = cell_addr(csel[0], csel[1], csel[2]);
   assign wp_valid    = (state_ff == ST_CORNER);

   assign read_oob = (32'(cell_ff[0]) >= 32'(GRID_DIM)) ||
                     (32'(cell_ff[1]) >= 32'(GRID_DIM)) ||
                     (32'(cell_ff[2]) >= 32'(GRID_DIM));

   // Memory request: clear sweep, corner accumulate or cell read, by state.
   always_comb begin
      mreq    = '0;
      maddr   = cell_addr(IW'(cell_ff[0]), IW'(cell_ff[1]), IW'(cell_ff[2]));
      maddend = wp_contrib;
      if (state_ff == ST_INIT) begin
         mreq.valid = 1'b1;
         mreq.kind  = cdd_pkg::MK_CLEAR;
         maddr      = clr_addr_ff;
      end else if (wp_out_valid) begin
         mreq.valid = 1'b1;
         mreq.kind  = cdd_pkg::MK_ADD;
         maddr      = wp_addr;
      end else if (state_ff == ST_READ && !read_oob) begin
         mreq.valid = 1'b1;
         mreq.kind  = (op_ff == cdd_pkg::OP_READ_CLEAR) ? cdd_pkg::MK_RDCLR
                                                         : cdd_pkg::MK_READ;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      sp_cnt_in    = sp_cnt_ff;
      oob_in       = oob_ff;
      cn_in        = cn_ff;
      rsp_valid_in = 1'b0;
      rsp_den_in   = mrd_den;
      rsp_sat_in   = mrd_sat;
      case (state_ff)
         ST_INIT: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  cdd_pkg::OP_DEPOSIT: begin
                     state_in  = ST_SPLIT;
                     sp_cnt_in = 2'd0;
                     oob_in    = 1'b0;
                  end
                  cdd_pkg::OP_READ, cdd_pkg::OP_READ_CLEAR: begin
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SPLIT: begin
            sp_cnt_in = sp_cnt_ff + 2'd1;
            if (sp_cnt_ff != 2'd0) oob_in = oob_ff | axis_oob;
            if (sp_cnt_ff == 2'd3) begin
               cn_in    = 3'd0;
               state_in = (oob_ff | axis_oob) ? ST_IDLE : ST_CORNER;
            end
         end
         ST_CORNER: begin
            cn_in = cn_ff + 3'd1;
            if (cn_ff == 3'd7) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // Hold until every corner has been written back.
            if (!wp_busy && !mpending) state_in = ST_IDLE;
         end
         ST_READ: begin
            if (read_oob) begin
               rsp_valid_in = 1'b1;
               rsp_den_in   = '0;
               rsp_sat_in   = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_WAITRD;
            end
         end
         ST_WAITRD: begin
            rsp_valid_in = mrd_valid;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_addr_ff  <= '0;
         sp_cnt_ff    <= '0;
         oob_ff       <= 1'b0;
         cn_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         sp_cnt_ff    <= sp_cnt_in;
         oob_ff       <= oob_in;
         cn_ff        <= cn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_den_ff <= rsp_den_in;
      rsp_sat_ff <= rsp_sat_in;
      if (accept) begin
         op_ff      <= req_operation;
         pos_ff[0]  <= req_pos_x;
         pos_ff[1]  <= req_pos_y;
         pos_ff[2]  <= req_pos_z;
         cell_ff[0] <= req_cell_x;
         cell_ff[1] <= req_cell_y;
         cell_ff[2] <= req_cell_z;
      end
      if (state_ff == ST_SPLIT) begin
         g_ff <= g_in;
         if (sp_cnt_ff != 2'd0) begin
            lo_ff[ax_prev]   <= g_ff[32 +: IW];
            frac_ff[ax_prev] <= g_ff[31:16];
         end
      end
   end

   cdd_weight_pipe #(
      .AW(AW)
   ) u_weight (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (wp_valid),
      .in_a        (fac[0]),
      .in_b        (fac[1]),
      .in_c        (fac[2]),
      .in_addr     (corner_addr),
      .scaled_mass (mass_ff),
      .out_valid   (wp_out_valid),
      .out_contrib (wp_contrib),
      .out_addr    (wp_addr),
      .busy        (wp_busy)
   );

   cdd_grid_mem #(
      .CELLS(CELLS),
      .AW   (AW)
   ) u_grid (
      .clock        (clock),
      .reset        (reset),
      .req          (mreq),
      .req_addr     (maddr),
      .req_addend   (maddend),
      .rd_valid     (mrd_valid),
      .rd_density   (mrd_den),
      .rd_saturated (mrd_sat),
      .pending      (mpending)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_density = rsp_den_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule
